FILE: rtl/a85_pkg.sv
`default_nettype none
package a85_pkg;

    localparam int unsigned A85_QUEUE_DEPTH = 4;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_INVALID     = 3'd1,
        ST_OVERFLOW    = 3'd2,
        ST_MISPLACED_Z = 3'd3,
        ST_LONE_DIGIT  = 3'd4
    } a85_status_t;

    // One request from the decode front to the byte back end.
    // Byte k of the request is word[31-8k -: 8]; bytes 0..last_idx are sent.
    typedef struct packed {
        logic [31:0] word;
        logic [1:0]  last_idx;
        logic        eos;
        a85_status_t status;
    } a85_entry_t;

endpackage
`default_nettype wire

FILE: rtl/a85_front.sv
`default_nettype none
module a85_front (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [7:0]         s_tdata,     // [7:0] char_code
    input  wire logic               q_full,
    output logic                    q_push,
    output a85_pkg::a85_entry_t     q_entry
);
    import a85_pkg::*;

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_FIRST = 8'h21;   // '!'
    localparam logic [7:0] CH_LAST  = 8'h75;   // 'u'
    localparam logic [7:0] CH_GT    = 8'h3E;   // '>'
    localparam logic [7:0] CH_Z     = 8'h7A;   // 'z'
    localparam logic [7:0] CH_TILDE = 8'h7E;   // '~'
    localparam logic [19:0] DIGIT_BASE = 20'd85;

    // 85^(5-k): scale for a final group of k digits padded with 'u'
    function automatic logic [19:0] pad_scale(input logic [2:0] k);
        logic [19:0] s;
        case (k)
            3'd2:    s = 20'd614125;
            3'd3:    s = 20'd7225;
            default: s = DIGIT_BASE;
        endcase
        return s;
    endfunction

    logic [25:0] gv_reg, gv_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic        tilde_reg, tilde_next;

    logic        accept;
    logic        is_ws;
    logic        is_tilde;
    logic [6:0]  digit;
    logic [19:0] scale;
    logic [19:0] addend;
    logic [45:0] prod;
    logic [32:0] sum;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign is_ws    = (s_tdata == CH_SPACE) || (s_tdata >= CH_TAB && s_tdata <= CH_CR);
    assign is_tilde = (s_tdata == CH_TILDE);
    assign digit    = 7'(s_tdata - CH_FIRST);

    // Shared multiply-add: gv*85 + digit for a data digit, gv*P + (P-1) for padding.
    assign scale  = is_tilde ? pad_scale(cnt_reg) : DIGIT_BASE;
    assign addend = is_tilde ? (scale - 20'd1) : {13'd0, digit};
    assign prod   = gv_reg * scale;
    assign sum    = prod[32:0] + {13'd0, addend};

    always_comb begin
        gv_next    = gv_reg;
        cnt_next   = cnt_reg;
        tilde_next = tilde_reg;
        q_push     = 1'b0;
        q_entry    = '{word: '0, last_idx: '0, eos: 1'b0, status: ST_OK};
        if (accept && !is_ws) begin
            tilde_next = 1'b0;
            if (!(tilde_reg && s_tdata == CH_GT)) begin
                case (s_tdata) inside
                    [CH_FIRST:CH_LAST]: begin
                        if (cnt_reg < 3'd4) begin
                            gv_next  = sum[25:0];
                            cnt_next = cnt_reg + 3'd1;
                        end else begin
                            gv_next  = '0;
                            cnt_next = '0;
                            q_push   = 1'b1;
                            if (sum[32]) begin
                                q_entry.status = ST_OVERFLOW;
                            end else begin
                                q_entry.word     = sum[31:0];
                                q_entry.last_idx = 2'd3;
                            end
                        end
                    end
                    CH_Z: begin
                        gv_next  = '0;
                        cnt_next = '0;
                        q_push   = 1'b1;
                        if (cnt_reg != 3'd0) begin
                            q_entry.status = ST_MISPLACED_Z;
                        end else begin
                            q_entry.last_idx = 2'd3;
                        end
                    end
                    CH_TILDE: begin
                        gv_next     = '0;
                        cnt_next    = '0;
                        tilde_next  = 1'b1;
                        q_push      = 1'b1;
                        q_entry.eos = 1'b1;
                        if (cnt_reg == 3'd1) begin
                            q_entry.status = ST_LONE_DIGIT;
                        end else if (cnt_reg != 3'd0) begin
                            if (sum[32]) begin
                                q_entry.status = ST_OVERFLOW;
                            end else begin
                                q_entry.word     = sum[31:0];
                                q_entry.last_idx = 2'(cnt_reg - 3'd2);
                            end
                        end
                    end
                    default: begin
                        gv_next        = '0;
                        cnt_next       = '0;
                        q_push         = 1'b1;
                        q_entry.status = ST_INVALID;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gv_reg    <= '0;
            cnt_reg   <= '0;
            tilde_reg <= 1'b0;
        end else begin
            gv_reg    <= gv_next;
            cnt_reg   <= cnt_next;
            tilde_reg <= tilde_next;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/a85_queue.sv
`default_nettype none
module a85_queue #(
    parameter int unsigned DEPTH = a85_pkg::A85_QUEUE_DEPTH
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                push,
    input  wire a85_pkg::a85_entry_t push_data,
    output logic                     full,
    input  wire logic                pop,
    output a85_pkg::a85_entry_t      pop_data,
    output logic                     not_empty
);
    import a85_pkg::*;

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    a85_entry_t    slots_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    assign full      = (cnt_reg == FULL_CNT);
    assign not_empty = (cnt_reg != '0);
    assign pop_data  = slots_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + CW'(1);
        end else if (pop && !push) begin
            cnt_next = cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slots_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/a85_back.sv
`default_nettype none
module a85_back (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                q_valid,
    input  wire a85_pkg::a85_entry_t q_data,
    output logic                     q_pop,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [7:0]               m_tdata,   // [7:0] out_byte
    output logic                     m_tlast,   // last_of_run
    output logic [3:0]               m_tuser    // [0] end_of_stream, [3:1] status
);
    import a85_pkg::*;

    logic       cur_valid_reg, cur_valid_next;
    a85_entry_t cur_reg, cur_next;
    logic [1:0] idx_reg, idx_next;
    logic       done;

    assign done  = cur_valid_reg && m_tready && (idx_reg == cur_reg.last_idx);
    assign q_pop = q_valid && (!cur_valid_reg || done);

    always_comb begin
        cur_valid_next = cur_valid_reg;
        cur_next       = cur_reg;
        idx_next       = idx_reg;
        if (q_pop) begin
            cur_valid_next = 1'b1;
            cur_next       = q_data;
            idx_next       = '0;
        end else if (done) begin
            cur_valid_next = 1'b0;
        end else if (cur_valid_reg && m_tready) begin
            idx_next = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end else begin
            cur_valid_reg <= cur_valid_next;
            idx_reg       <= idx_next;
        end
        cur_reg <= cur_next;
    end

    // most significant byte first
    assign m_tvalid = cur_valid_reg;
    assign m_tdata  = cur_reg.word[{~idx_reg, 3'b000} +: 8];
    assign m_tlast  = (idx_reg == cur_reg.last_idx);
    assign m_tuser  = {cur_reg.status, cur_reg.eos};

endmodule
`default_nettype wire

FILE: rtl/ascii85_stream_decoder_core.sv
// ASCII85 stream decoder.
// Slave channel (s_tvalid/s_tready/s_tdata): one encoded character per request.
// Master channel (m_tvalid/m_tready/m_tdata/m_tlast/m_tuser): decoded bytes, most
// significant first; m_tlast marks the last result of a character, m_tuser holds
// end_of_stream in bit 0 and the status code in bits 3:1 (out_byte is 0 on errors).
// Whitespace and a '>' right after '~' produce nothing; a completed group gives four
// bytes, 'z' four zeros, '~' the padded tail or one end marker; errors give one result.
// With an idle back end the first result of a character is written into the queue
// at its accept edge and then into the back end register that drives m_tvalid.
// Throughput: one character per cycle while the request queue has room; the back end
// sends one byte per cycle while m_tready is high, so 'z' and fifth digits (four bytes)
// fill the queue of QUEUE_DEPTH requests and s_tready drops until one is popped.
// The group accumulator does one multiply-add by a constant per character.
// When m_tready is low the current byte holds and the front keeps accepting until
// the queue is full.
// Reset (aresetn low, synchronous) clears the group, the end marker flag, the queue
// and the output valid; no clearing pass is needed afterwards.
`default_nettype none
module ascii85_stream_decoder_core #(
    parameter int unsigned QUEUE_DEPTH = a85_pkg::A85_QUEUE_DEPTH
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] char_code
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [7:0] out_byte
    output logic            m_tlast,   // last_of_run
    output logic [3:0]      m_tuser    // [0] end_of_stream, [3:1] status
);
    import a85_pkg::*;

    logic       q_full;
    logic       q_push;
    a85_entry_t q_entry;
    logic       q_pop;
    a85_entry_t q_head;
    logic       q_valid;

    a85_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_entry  (q_entry)
    );

    a85_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_entry),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_head),
        .not_empty (q_valid)
    );

    a85_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_data   (q_head),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

`ifndef SYNTHESIS
    a_no_push_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> !q_full)
        else $error("request pushed into a full queue");

    a_error_single_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser[3:1] != ST_OK) |-> m_tlast && (m_tdata == 8'd0))
        else $error("error result is not a single zero byte");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && !q_valid)
        else $error("output or queue not idle after reset");

    a_pop_needs_data: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_valid)
        else $error("pop from an empty queue");
`endif

endmodule
`default_nettype wire
